// File: hw/rtl/hncls_pkg.sv
// ----------------------------------------------------------------------------
// Header name classifier package
// Constants and the table of well-known header names for the header name
// classifier and hash block.
// ----------------------------------------------------------------------------
package hncls_pkg;

  // Number of well-known names and the widest one in bytes.
  localparam int KnownNames = 31;
  localparam int NameSlot   = 24;

  // Field widths.
  localparam int ByteW  = 8;
  localparam int IdW    = 5;
  localparam int HashW  = 32;
  localparam int BucketW = 8;
  localparam int CountW = 6;
  localparam int PosW   = 5;

  // Packed result word: id, hash, bucket, length, zero filled to bytes.
  localparam int ResultBits = IdW + HashW + BucketW + CountW;
  localparam int ResultW    = ((ResultBits + 7) / 8) * 8;

  // Hash seed, length saturation value and bucket count.
  localparam logic [HashW-1:0]  HashSeed    = 32'd5381;
  localparam logic [CountW-1:0] CountMax    = 6'd63;
  localparam int                BucketCount = 256;

  // ASCII letter bounds and the bit that lowers a letter's case.
  localparam logic [ByteW-1:0] UpperA   = 8'h41;
  localparam logic [ByteW-1:0] UpperZ   = 8'h5A;
  localparam logic [ByteW-1:0] CaseBit  = 8'h20;

  // Name text, right aligned: the first character sits in the highest used byte.
  localparam logic [8*NameSlot-1:0] KnownText [KnownNames] = '{
    "host", "content-type", "content-length", "authorization", "cookie",
    "set-cookie", "accept", "accept-encoding", "accept-language",
    "user-agent", "connection", "upgrade", "cache-control", "origin",
    "referer", "sec-websocket-key", "sec-websocket-version",
    "sec-websocket-extensions", "sec-websocket-protocol",
    "transfer-encoding", "location", "if-modified-since", "if-none-match",
    "etag", "server", "date", "vary", "x-request-id", "x-forwarded-for",
    "x-real-ip", "content-encoding"
  };

  // Length of each name in bytes.
  localparam logic [CountW-1:0] KnownLen [KnownNames] = '{
    6'd4,  6'd12, 6'd14, 6'd13, 6'd6,  6'd10, 6'd6,  6'd15, 6'd15, 6'd10,
    6'd10, 6'd7,  6'd13, 6'd6,  6'd7,  6'd17, 6'd21, 6'd24, 6'd22, 6'd17,
    6'd8,  6'd17, 6'd13, 6'd4,  6'd6,  6'd4,  6'd4,  6'd12, 6'd15, 6'd9,
    6'd16
  };

  // Fold an ASCII upper-case letter to lower case; other bytes pass as they are.
  function automatic logic [ByteW-1:0] fold_case(input logic [ByteW-1:0] c);
    logic [ByteW-1:0] r;
    r = c;
    if (c >= UpperA && c <= UpperZ) begin
      r = c | CaseBit;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/hncls_match.sv
// ----------------------------------------------------------------------------
// Header name matcher
// Narrows the set of well-known names that still match the bytes seen so far
// and picks the matching name id once the name is complete.
// ----------------------------------------------------------------------------
module hncls_match
  import hncls_pkg::*;
(
  input  logic [KnownNames-1:0] mask,       // names still matching before this byte
  input  logic [CountW-1:0]     pos,        // position of this byte in the name
  input  logic [ByteW-1:0]      lower_byte, // byte after case folding
  input  logic [CountW-1:0]     count_next, // name length including this byte
  output logic [KnownNames-1:0] mask_next,
  output logic [IdW-1:0]        id
);

  // Each candidate survives only if the name is long enough and the byte agrees.
  always_comb begin
    logic [PosW-1:0]  offset;
    logic [ByteW-1:0] expect_char;
    mask_next = '0;
    for (int i = 0; i < KnownNames; i++) begin
      offset      = PosW'(KnownLen[i] - 6'd1 - pos);
      expect_char = KnownText[i][{offset, 3'b000} +: ByteW];
      mask_next[i] = mask[i] && (pos < KnownLen[i]) && (expect_char == lower_byte);
    end
  end

  // The lowest candidate whose length equals the count wins; none gives zero.
  always_comb begin
    id = '0;
    for (int i = KnownNames - 1; i >= 0; i--) begin
      if (mask_next[i] && KnownLen[i] == count_next) begin
        id = IdW'(i + 1);
      end
    end
  end

endmodule

// File: hw/rtl/header_name_classify_hash_top.sv
// ----------------------------------------------------------------------------
// Header name classifier and hash
// Recognizes well-known HTTP header names and computes a case-folded hash.
// ----------------------------------------------------------------------------
// Usage:
//   The slave side takes one name byte per request in s_tdata, with s_tlast
//   on the final byte of a name. Bytes A-Z are folded to lower case, then
//   feed a djb2 hash (seed 5381, times 33 plus byte), a length count that
//   saturates at 63, and a mask of the well-known names still matching.
//   One result request leaves the master side per name, after its last byte:
//   the name id (0 when unknown), the hash, the bucket and the length.
//   A last byte is held in the input register and then in the result
//   register, which raises m_tvalid.
//   One byte per cycle is taken while no final byte waits behind a stalled
//   result; the input register and the result register each hold one
//   request, and the state update is combinational logic between them.
//   When the receiver stalls, a waiting result holds and non-final bytes are
//   still taken; a final byte waits in the input register until the result
//   register frees, and s_tready drops behind it.
//   Reset empties both registers and returns the hash to 5381, the count to
//   zero and the name mask to all ones.
// ----------------------------------------------------------------------------
module header_name_classify_hash_top
  import hncls_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [ByteW-1:0]   s_tdata,  // [7:0] name_byte
  input  logic               s_tlast,  // last_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [ResultW-1:0] m_tdata   // [4:0] header_id, [36:5] name_hash,
                                       // [44:37] bucket_index, [50:45] name_length
);

  // Input register.
  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             in_last;

  // Running name state.
  logic [HashW-1:0]      running_hash;
  logic [CountW-1:0]     byte_count;
  logic [KnownNames-1:0] candidate_mask;

  // Result register.
  logic [IdW-1:0]     out_id;
  logic [HashW-1:0]   out_hash;
  logic [BucketW-1:0] out_bucket;
  logic [CountW-1:0]  out_len;

  logic                  advance;
  logic [ByteW-1:0]      lower_byte;
  logic [HashW-1:0]      running_hash_next;
  logic [CountW-1:0]     byte_count_next;
  logic [KnownNames-1:0] candidate_mask_next;
  logic [IdW-1:0]        id_next;

  // A byte moves on unless it is final and the result register is still full.
  assign advance  = in_valid && (!in_last || !m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Hash and length update for the byte in the input register.
  assign lower_byte        = fold_case(in_byte);
  assign running_hash_next = {running_hash[HashW-6:0], 5'b00000} + running_hash
                             + {{(HashW-ByteW){1'b0}}, lower_byte};
  assign byte_count_next   = (byte_count == CountMax) ? CountMax : byte_count + 6'd1;

  hncls_match u_match (
    .mask       (candidate_mask),
    .pos        (byte_count),
    .lower_byte (lower_byte),
    .count_next (byte_count_next),
    .mask_next  (candidate_mask_next),
    .id         (id_next)
  );

  // Input register load.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  // Name state: updated per byte, cleared after the final byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash   <= HashSeed;
      byte_count     <= '0;
      candidate_mask <= '1;
    end else if (advance) begin
      if (in_last) begin
        running_hash   <= HashSeed;
        byte_count     <= '0;
        candidate_mask <= '1;
      end else begin
        running_hash   <= running_hash_next;
        byte_count     <= byte_count_next;
        candidate_mask <= candidate_mask_next;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (advance && in_last) begin
      out_id     <= id_next;
      out_hash   <= running_hash_next;
      out_bucket <= BucketW'(running_hash_next % HashW'(BucketCount));
      out_len    <= byte_count_next;
    end
  end

  // Pack the result fields, lowest field first.
  assign m_tdata = {{(ResultW-ResultBits){1'b0}}, out_len, out_bucket, out_hash, out_id};

`ifndef SYNTH
  // A final byte that moves on always shows a result next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> m_tvalid)
    else $error("final byte did not produce a result");

  // State returns to its starting values after every name.
  a_state_cleared: assert property (@(posedge clk) disable iff (rst)
    advance && in_last |=> (running_hash == HashSeed && byte_count == '0 &&
                            candidate_mask == '1))
    else $error("name state not cleared after final byte");

  // A held input byte is only ever a final byte behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_valid && !s_tready |-> in_last && m_tvalid && !m_tready)
    else $error("input stalled without a blocked result");

  // A result never reports an empty name.
  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_len != '0)
    else $error("result with zero length");

  // A known id always agrees with its name's length.
  a_id_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_id != '0 |-> out_len == KnownLen[out_id - 5'd1])
    else $error("known id with wrong length");
`endif

endmodule
